>>> design/access_pattern_block_predictor_top_defines.svh
// Assertion macros used by the checker of the predictor.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef ACCESS_PATTERN_BLOCK_PREDICTOR_TOP_DEFINES_SVH
`define ACCESS_PATTERN_BLOCK_PREDICTOR_TOP_DEFINES_SVH

// same-cycle implication
`define APBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apbp check failed");

// next-cycle implication
`define APBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apbp check failed");

`endif

>>> design/apbp_pkg.sv
// Types and codes of the block predictor.
// Used by the top level and the testbench; depends on nothing.
package apbp_pkg;

    localparam int FILL_W    = 7;
    localparam int RES_LIMIT = 16;

    typedef enum logic [1:0] {
        FN_RECORD  = 2'd0,
        FN_PREDICT = 2'd1,
        FN_CLEANUP = 2'd2,
        FN_NOP     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_SEQ_FULL  = 2'd2,
        ST_CNT_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_EV,
        S_CNT_CHK,
        S_CNT_RD,
        S_CNT_EV,
        S_UPD,
        S_BEST_CHK,
        S_BEST_RD,
        S_BEST_EV,
        S_SEQWR,
        S_PSEL,
        S_PNEXT,
        S_CLN_RD,
        S_CLN_EV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0]       tag;
        logic [63:0]       last_time;
        logic [31:0]       last_block;
        logic [1:0]        hist;
        logic              seqf;
        logic [31:0]       pred;
        logic [FILL_W-1:0] fill;
    } seq_word_t;

    typedef struct packed {
        logic [31:0] blk;
        logic [31:0] value;
    } cnt_word_t;

    typedef struct packed {
        logic [31:0] blk;
        logic        valid;
        logic        seqf;
        logic        last;
        status_t     status;
        logic [4:0]  removed;
    } res_t;

    // higher count first, then lower block id
    function automatic logic ranks_above(cnt_word_t a, cnt_word_t b);
        logic r;
        if (a.value != b.value)
            r = a.value > b.value;
        else
            r = a.blk < b.blk;
        return r;
    endfunction

endpackage

>>> design/access_pattern_block_predictor_top.sv
// Block predictor: a sequencer walks the sequence RAM and the count RAM (one port each,
// registered read). A record searches the sequence table, then the counts of its entry,
// and rescans the counts for the best block unless the entry is sequential; a cleanup
// walks the sequence table; a predict searches it, then gives each result directly when
// sequential or after a scan of the counts by frequency.
// One request at a time; async active-low reset empties the table, max_age 1e9.
module access_pattern_block_predictor_top #(
    parameter int SEQ_ENTRIES     = 16,
    parameter int COUNT_ENTRIES   = 16,
    parameter int MAX_PREDICTIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] max_age,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [63:0] sequence_id,
    input  logic [31:0] block_id,
    input  logic [63:0] timestamp,
    input  logic [4:0]  num_predictions,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] block_out,
    output logic        valid_res,
    output logic        sequential,
    output logic        last,
    output logic [1:0]  status,
    output logic [4:0]  removed
);
    import apbp_pkg::*;

    localparam int SW   = (SEQ_ENTRIES > 1) ? $clog2(SEQ_ENTRIES) : 1;
    localparam int CIW  = (COUNT_ENTRIES > 1) ? $clog2(COUNT_ENTRIES) : 1;
    localparam int CTOT = SEQ_ENTRIES * COUNT_ENTRIES;
    localparam int CAW  = (CTOT > 1) ? $clog2(CTOT) : 1;
    localparam int LIM  = (MAX_PREDICTIONS < RES_LIMIT) ? MAX_PREDICTIONS : RES_LIMIT;

    state_t state_reg, state_next;
    logic [SEQ_ENTRIES-1:0] seq_valid_reg;
    logic [63:0] max_age_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;

    func_t       func_reg;
    logic [63:0] tag_reg;
    logic [31:0] blk_reg;
    logic [63:0] ts_reg;
    logic [4:0]  req_reg;
    logic [SW-1:0] idx_reg, sidx_reg, free_idx_reg;
    logic        free_found_reg;
    seq_word_t   w_reg;
    logic [FILL_W-1:0] c_reg;
    logic        hit_reg;
    logic [31:0] hitv_reg;
    status_t     status_reg;
    logic        best_found_reg;
    cnt_word_t   best_reg;
    logic [CIW-1:0] best_c_reg;
    logic [COUNT_ENTRIES-1:0] used_reg;
    logic [4:0]  k_reg, n_reg;
    logic        seqmode_reg;
    logic [4:0]  removed_reg;
    res_t        res_reg;

    seq_word_t   seq_rdata;
    cnt_word_t   cnt_rdata, cnt_wdata;
    logic        seq_we, cnt_we;
    logic [SW-1:0]  seq_addr;
    logic [CAW-1:0] cnt_addr;

    logic idx_last, hit_now, free_now, eff_free, cnt_full, seqf_new, stale;
    logic slot_free, cand_better;
    logic [SW-1:0] eff_free_idx;
    logic [4:0] p_n, p_cnt;
    logic [4:0] removed_new;

    apbp_ram #(.WIDTH($bits(seq_word_t)), .DEPTH(SEQ_ENTRIES)) u_seq_ram (
        .clk   (clk),
        .we    (seq_we),
        .addr  (seq_addr),
        .wdata (w_reg),
        .rdata (seq_rdata)
    );

    apbp_ram #(.WIDTH($bits(cnt_word_t)), .DEPTH(CTOT)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        idx_last     = idx_reg == SW'(SEQ_ENTRIES - 1);
        hit_now      = seq_valid_reg[idx_reg] && (seq_rdata.tag == tag_reg);
        free_now     = !seq_valid_reg[idx_reg];
        eff_free     = free_found_reg || free_now;
        eff_free_idx = free_found_reg ? free_idx_reg : idx_reg;
        cnt_full     = w_reg.fill == FILL_W'(COUNT_ENTRIES);
        seqf_new     = (w_reg.hist != 2'd0) ? (blk_reg == w_reg.last_block + 32'd1)
                                             : w_reg.seqf;
        stale        = (ts_reg - seq_rdata.last_time) > max_age_reg;
        removed_new  = (removed_reg != 5'd31) ? removed_reg + 5'd1 : removed_reg;
        slot_free    = !out_valid_reg || out_ready;
        cand_better  = !used_reg[c_reg[CIW-1:0]] &&
                       (!best_found_reg || ranks_above(cnt_rdata, best_reg));
        p_n          = (req_reg > 5'(LIM)) ? 5'(LIM) : req_reg;
        p_cnt        = ({2'b00, p_n} > w_reg.fill) ? 5'(w_reg.fill) : p_n;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (func_t'(func))
                        FN_RECORD, FN_PREDICT: state_next = S_FIND_RD;
                        FN_CLEANUP:            state_next = S_CLN_RD;
                        default:               state_next = S_EMIT;
                    endcase
                end
            end
            S_FIND_RD: state_next = S_FIND_EV;
            S_FIND_EV:
            begin
                if (hit_now)
                    state_next = (func_reg == FN_RECORD) ? S_CNT_CHK : S_PSEL;
                else if (idx_last)
                    state_next = (func_reg == FN_RECORD && eff_free) ? S_CNT_CHK : S_EMIT;
                else
                    state_next = S_FIND_RD;
            end
            S_CNT_CHK: state_next = (c_reg == w_reg.fill) ? S_UPD : S_CNT_RD;
            S_CNT_RD:  state_next = S_CNT_EV;
            S_CNT_EV:  state_next = (cnt_rdata.blk == blk_reg) ? S_UPD : S_CNT_CHK;
            S_UPD:     state_next = seqf_new ? S_SEQWR : S_BEST_CHK;
            S_BEST_CHK:
            begin
                if (c_reg != w_reg.fill)
                    state_next = S_BEST_RD;
                else
                    state_next = (func_reg == FN_RECORD) ? S_SEQWR : S_EMIT;
            end
            S_BEST_RD: state_next = S_BEST_EV;
            S_BEST_EV: state_next = S_BEST_CHK;
            S_SEQWR:   state_next = S_EMIT;
            S_PSEL:
            begin
                if (w_reg.seqf && w_reg.hist == 2'd2)
                    state_next = S_EMIT;
                else
                    state_next = (p_cnt == 5'd0) ? S_EMIT : S_BEST_CHK;
            end
            S_PNEXT:   state_next = seqmode_reg ? S_EMIT : S_BEST_CHK;
            S_CLN_RD:  state_next = S_CLN_EV;
            S_CLN_EV:  state_next = idx_last ? S_EMIT : S_CLN_RD;
            S_EMIT:
            begin
                if (slot_free)
                    state_next = res_reg.last ? S_IDLE : S_PNEXT;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        cfg_ready = 1'b1;
        seq_we    = state_reg == S_SEQWR;
        seq_addr  = (state_reg == S_SEQWR) ? sidx_reg : idx_reg;
        cnt_addr  = CAW'(sidx_reg) * CAW'(COUNT_ENTRIES) + CAW'(c_reg);
        cnt_we    = (state_reg == S_UPD) && (hit_reg || !cnt_full);
        cnt_wdata.blk   = blk_reg;
        cnt_wdata.value = hit_reg ? ((hitv_reg != 32'hFFFF_FFFF) ? hitv_reg + 32'd1 : hitv_reg)
                                  : 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seq_valid_reg <= '0;
            max_age_reg   <= 64'd1000000000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                max_age_reg <= max_age;
            if (state_reg == S_SEQWR)
                seq_valid_reg[sidx_reg] <= 1'b1;
            if (state_reg == S_CLN_EV && seq_valid_reg[idx_reg] && stale)
                seq_valid_reg[idx_reg] <= 1'b0;
            if (state_reg == S_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg       <= func_t'(func);
                tag_reg        <= sequence_id;
                blk_reg        <= block_id;
                ts_reg         <= timestamp;
                req_reg        <= num_predictions;
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
                removed_reg    <= 5'd0;
                res_reg        <= '{32'd0, 1'b0, 1'b0, 1'b1, ST_OK, 5'd0};
            end
            S_FIND_EV:
            begin
                c_reg      <= '0;
                hit_reg    <= 1'b0;
                status_reg <= ST_OK;
                if (hit_now)
                begin
                    sidx_reg <= idx_reg;
                    w_reg    <= seq_rdata;
                end
                else
                begin
                    if (free_now && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    idx_reg <= idx_reg + SW'(1);
                    if (idx_last)
                    begin
                        sidx_reg <= eff_free_idx;
                        w_reg    <= '{tag_reg, 64'd0, 32'd0, 2'd0, 1'b0, 32'd0, FILL_W'(0)};
                        res_reg  <= '{32'd0, 1'b0, 1'b0, 1'b1,
                                      (func_reg == FN_RECORD) ? ST_SEQ_FULL : ST_NOT_FOUND,
                                      5'd0};
                    end
                end
            end
            S_CNT_EV:
            begin
                hitv_reg <= cnt_rdata.value;
                if (cnt_rdata.blk == blk_reg)
                    hit_reg <= 1'b1;
                else
                    c_reg <= c_reg + FILL_W'(1);
            end
            S_UPD:
            begin
                w_reg.last_time  <= ts_reg;
                w_reg.last_block <= blk_reg;
                w_reg.seqf       <= seqf_new;
                if (w_reg.hist != 2'd2)
                    w_reg.hist <= w_reg.hist + 2'd1;
                if (!hit_reg && !cnt_full)
                    w_reg.fill <= w_reg.fill + FILL_W'(1);
                if (!hit_reg && cnt_full)
                    status_reg <= ST_CNT_FULL;
                if (seqf_new)
                    w_reg.pred <= blk_reg + 32'd1;
                c_reg          <= '0;
                used_reg       <= '0;
                best_found_reg <= 1'b0;
            end
            S_BEST_EV:
            begin
                if (cand_better)
                begin
                    best_reg       <= cnt_rdata;
                    best_c_reg     <= c_reg[CIW-1:0];
                    best_found_reg <= 1'b1;
                end
                c_reg <= c_reg + FILL_W'(1);
            end
            S_BEST_CHK:
            begin
                if (c_reg == w_reg.fill)
                begin
                    if (func_reg == FN_RECORD)
                        w_reg.pred <= best_reg.blk;
                    else
                    begin
                        used_reg[best_c_reg] <= 1'b1;
                        res_reg <= '{best_reg.blk, 1'b1, w_reg.seqf,
                                     k_reg == n_reg - 5'd1, ST_OK, 5'd0};
                    end
                end
            end
            S_SEQWR:
                res_reg <= '{w_reg.pred, 1'b1, w_reg.seqf, 1'b1, status_reg, 5'd0};
            S_PSEL:
            begin
                k_reg          <= 5'd0;
                c_reg          <= '0;
                used_reg       <= '0;
                best_found_reg <= 1'b0;
                if (w_reg.seqf && w_reg.hist == 2'd2)
                begin
                    seqmode_reg <= 1'b1;
                    n_reg       <= p_n;
                    if (p_n == 5'd0)
                        res_reg <= '{32'd0, 1'b0, 1'b1, 1'b1, ST_OK, 5'd0};
                    else
                        res_reg <= '{w_reg.last_block + 32'd1, 1'b1, 1'b1,
                                     p_n == 5'd1, ST_OK, 5'd0};
                end
                else
                begin
                    seqmode_reg <= 1'b0;
                    n_reg       <= p_cnt;
                    res_reg     <= '{32'd0, 1'b0, w_reg.seqf, 1'b1, ST_OK, 5'd0};
                end
            end
            S_PNEXT:
            begin
                // advance to the next result of a predict request
                k_reg          <= k_reg + 5'd1;
                c_reg          <= '0;
                best_found_reg <= 1'b0;
                res_reg <= '{w_reg.last_block + 32'(k_reg) + 32'd2, 1'b1, 1'b1,
                             k_reg + 5'd2 == n_reg, ST_OK, 5'd0};
            end
            S_CLN_EV:
            begin
                if (seq_valid_reg[idx_reg] && stale)
                    removed_reg <= removed_new;
                idx_reg <= idx_reg + SW'(1);
                res_reg <= '{32'd0, 1'b0, 1'b0, 1'b1, ST_OK,
                             (seq_valid_reg[idx_reg] && stale) ? removed_new : removed_reg};
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EMIT && slot_free)
            out_res_reg <= res_reg;
    end

    assign out_valid  = out_valid_reg;
    assign block_out  = out_res_reg.blk;
    assign valid_res  = out_res_reg.valid;
    assign sequential = out_res_reg.seqf;
    assign last       = out_res_reg.last;
    assign status     = out_res_reg.status;
    assign removed    = out_res_reg.removed;
endmodule

>>> design/apbp_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module apbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> design/apbp_checker.sv
// Port-level checks of the block predictor, bound to the top level.
// Depends on the assertion macro header.
module apbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] block_out,
    input logic        valid_res,
    input logic [1:0]  status,
    input logic [4:0]  removed
);
`include "access_pattern_block_predictor_top_defines.svh"

    `APBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `APBP_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `APBP_ASSERT_NOW(a_empty_block, out_valid && !valid_res, block_out == 32'd0)
    `APBP_ASSERT_NOW(a_removed_only_ok, out_valid && removed != 5'd0,
                     status == 2'd0 && !valid_res)
endmodule

bind access_pattern_block_predictor_top apbp_checker u_apbp_checker (.*);

>>> tb/sv/tb_access_pattern_block_predictor_top.sv
// Self-checking testbench of the access-pattern block predictor.
// Depends on apbp_pkg and access_pattern_block_predictor_top; an in-bench model or a
// directed row's own expectation gives every result, checked in order against the output.
`timescale 1ns / 1ps

module tb_access_pattern_block_predictor_top;
    import apbp_pkg::*;

    localparam int NSEQ = 16;
    localparam int NCNT = 16;
    localparam int MAXP = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct {
        logic [31:0] blk;
        bit          vld;
        bit          seqf;
        bit          fin;
        logic [1:0]  st;
        logic [4:0]  rem;
    } prediction_t;

    typedef struct {
        func_t       fn;
        logic [63:0] tag;
        logic [31:0] blk;
        logic [63:0] ts;
        logic [4:0]  np;
        bit          typed;
        prediction_t want;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] max_age;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [63:0] sequence_id;
    logic [31:0] block_id;
    logic [63:0] timestamp;
    logic [4:0]  num_predictions;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] block_out;
    logic        valid_res;
    logic        sequential;
    logic        last;
    logic [1:0]  status;
    logic [4:0]  removed;

    access_pattern_block_predictor_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_age(max_age),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .sequence_id(sequence_id), .block_id(block_id), .timestamp(timestamp),
        .num_predictions(num_predictions),
        .out_valid(out_valid), .out_ready(out_ready), .block_out(block_out),
        .valid_res(valid_res), .sequential(sequential), .last(last),
        .status(status), .removed(removed)
    );

    // model state
    logic [63:0] age_limit;
    bit          seq_live[NSEQ];
    logic [63:0] seq_key[NSEQ];
    logic [63:0] seq_seen_at[NSEQ];
    logic [31:0] seq_prev_blk[NSEQ];
    int          seq_depth[NSEQ];
    bit          seq_is_stride[NSEQ];
    logic [31:0] seq_next_guess[NSEQ];
    bit          cnt_live[NSEQ*NCNT];
    logic [31:0] cnt_blk[NSEQ*NCNT];
    logic [31:0] cnt_hits[NSEQ*NCNT];

    prediction_t pending_predictions[$];
    int  errors;
    bit  quiet;
    bit  hold_req;
    logic [63:0] clock_ts;
    logic [63:0] id_pool[20];
    logic [31:0] pool_blk[20];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void push_prediction(logic [31:0] b, bit v, bit sf, bit f,
                                            logic [1:0] st, logic [4:0] rm);
        prediction_t p;
        p.blk = b; p.vld = v; p.seqf = sf; p.fin = f; p.st = st; p.rem = rm;
        pending_predictions = {pending_predictions, p};
    endfunction

    function automatic int lookup_seq(logic [63:0] tag);
        int hit;
        hit = -1;
        for (int s = 0; s < NSEQ; s++)
            if (hit < 0 && seq_live[s] && seq_key[s] == tag)
                hit = s;
        return hit;
    endfunction

    function automatic bit outranks(int a, int b);
        bit r;
        if (cnt_hits[a] != cnt_hits[b])
            r = cnt_hits[a] > cnt_hits[b];
        else
            r = cnt_blk[a] < cnt_blk[b];
        return r;
    endfunction

    function automatic int top_count(int s, bit [NCNT-1:0] used);
        int best;
        int i;
        best = -1;
        for (int c = 0; c < NCNT; c++) begin
            i = s * NCNT + c;
            if (cnt_live[i] && !used[c] && (best < 0 || outranks(i, best)))
                best = i;
        end
        return best;
    endfunction

    function automatic void model_record(logic [63:0] tag, logic [31:0] blk,
                                         logic [63:0] ts);
        int s;
        int i;
        int hit;
        int freec;
        int b;
        logic [1:0] st;
        s = lookup_seq(tag);
        hit = -1;
        freec = -1;
        st = ST_OK;
        if (s < 0) begin
            for (int c = NSEQ - 1; c >= 0; c--)
                if (!seq_live[c])
                    s = c;
            if (s < 0) begin
                push_prediction(0, 0, 0, 1, ST_SEQ_FULL, 0);
                return;
            end
            seq_live[s] = 1;
            seq_key[s] = tag;
            seq_depth[s] = 0;
            seq_is_stride[s] = 0;
            seq_next_guess[s] = 0;
            for (int c = 0; c < NCNT; c++)
                cnt_live[s*NCNT + c] = 0;
        end
        seq_seen_at[s] = ts;
        for (int c = 0; c < NCNT; c++) begin
            i = s * NCNT + c;
            if (hit < 0) begin
                if (cnt_live[i]) begin
                    if (cnt_blk[i] == blk)
                        hit = i;
                end else if (freec < 0) begin
                    freec = i;
                end
            end
        end
        if (hit >= 0) begin
            if (cnt_hits[hit] != 32'hFFFF_FFFF)
                cnt_hits[hit]++;
        end else if (freec >= 0) begin
            cnt_live[freec] = 1;
            cnt_blk[freec] = blk;
            cnt_hits[freec] = 1;
        end else begin
            st = ST_CNT_FULL;
        end
        if (seq_depth[s] >= 1)
            seq_is_stride[s] = (blk == seq_prev_blk[s] + 32'd1);
        if (seq_depth[s] < 2)
            seq_depth[s]++;
        seq_prev_blk[s] = blk;
        if (seq_is_stride[s]) begin
            seq_next_guess[s] = blk + 32'd1;
        end else begin
            b = top_count(s, '0);
            if (b >= 0)
                seq_next_guess[s] = cnt_blk[b];
        end
        push_prediction(seq_next_guess[s], 1, seq_is_stride[s], 1, st, 0);
    endfunction

    function automatic void model_lookahead(logic [63:0] tag, logic [4:0] np);
        int s;
        int n;
        int k;
        int b;
        bit [NCNT-1:0] used;
        s = lookup_seq(tag);
        used = '0;
        if (s < 0) begin
            push_prediction(0, 0, 0, 1, ST_NOT_FOUND, 0);
            return;
        end
        n = (np > MAXP) ? MAXP : np;
        if (seq_is_stride[s] && seq_depth[s] >= 2) begin
            for (k = 0; k < n; k++)
                push_prediction(seq_prev_blk[s] + 32'(k + 1), 1, 1, k == n - 1, ST_OK, 0);
            if (n > 0)
                return;
        end else begin
            for (k = 0; k < n; k++) begin
                b = top_count(s, used);
                if (b < 0)
                    break;
                used[b - s*NCNT] = 1'b1;
                push_prediction(cnt_blk[b], 1, seq_is_stride[s], 0, ST_OK, 0);
            end
            if (k > 0) begin
                pending_predictions[$].fin = 1;
                return;
            end
        end
        push_prediction(0, 0, seq_is_stride[s], 1, ST_OK, 0);
    endfunction

    function automatic void model_cleanup(logic [63:0] now);
        logic [63:0] age;
        logic [4:0]  freed;
        freed = 0;
        for (int s = 0; s < NSEQ; s++) begin
            age = now - seq_seen_at[s];
            if (seq_live[s] && age > age_limit) begin
                seq_live[s] = 0;
                seq_depth[s] = 0;
                seq_is_stride[s] = 0;
                seq_next_guess[s] = 0;
                for (int c = 0; c < NCNT; c++)
                    cnt_live[s*NCNT + c] = 0;
                if (freed < 31)
                    freed++;
            end
        end
        push_prediction(0, 0, 0, 1, ST_OK, freed);
    endfunction

    function automatic void model_request(req_row_t r);
        int n;
        n = pending_predictions.size();
        case (r.fn)
            FN_RECORD:  model_record(r.tag, r.blk, r.ts);
            FN_PREDICT: model_lookahead(r.tag, r.np);
            FN_CLEANUP: model_cleanup(r.ts);
            default:    push_prediction(0, 0, 0, 1, ST_OK, 0);
        endcase
        if (r.typed) begin
            while (pending_predictions.size() > n)
                void'(pending_predictions.pop_back());
            pending_predictions = {pending_predictions, r.want};
        end
    endfunction

    task automatic send_request(req_row_t r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= r.fn;
        sequence_id <= r.tag;
        block_id <= r.blk;
        timestamp <= r.ts;
        num_predictions <= r.np;
        do @(posedge clk); while (!in_ready);
        model_request(r);
    endtask

    task automatic write_age_limit(logic [63:0] v);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        max_age <= v;
        do @(posedge clk); while (!cfg_ready);
        age_limit = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_predictions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic req_row_t plain_row(func_t fn, logic [63:0] tag, logic [31:0] blk,
                                           logic [63:0] ts, logic [4:0] np);
        req_row_t r;
        r.fn = fn; r.tag = tag; r.blk = blk; r.ts = ts; r.np = np; r.typed = 0;
        r.want = '{0, 0, 0, 1, ST_OK, 0};
        return r;
    endfunction

    function automatic req_row_t random_row();
        req_row_t r;
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, 19);
        clock_ts = clock_ts + 64'($urandom_range(0, 120));
        r = plain_row(FN_RECORD, id_pool[k], 0, clock_ts, 5'($urandom_range(0, 31)));
        if ($urandom_range(0, 19) == 0)
            r.tag = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0)
            r.ts = {$urandom, $urandom};
        if (pick < 50) begin
            case ($urandom_range(0, 5))
                0, 1, 2: r.blk = pool_blk[k] + 32'd1;
                3, 4:    r.blk = 32'(k * 64 + $urandom_range(0, 20));
                default: r.blk = $urandom;
            endcase
            pool_blk[k] = r.blk;
        end else if (pick < 78) begin
            r.fn = FN_PREDICT;
        end else if (pick < 93) begin
            r.fn = FN_CLEANUP;
        end else begin
            r.fn = FN_NOP;
            r.blk = $urandom;
        end
        return r;
    endfunction

    // output side: random stalls, plus one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (1500) @(posedge clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        prediction_t w;
        if (rst_n && out_valid && out_ready) begin
            if (pending_predictions.size() == 0) begin
                $display("%0t: unexpected result blk=%h st=%0d", $realtime, block_out, status);
                errors++;
            end else begin
                w = pending_predictions.pop_front();
                if (block_out !== w.blk || valid_res !== w.vld || sequential !== w.seqf
                    || last !== w.fin || status !== w.st || removed !== w.rem) begin
                    $display("%0t: expected blk=%h v=%0d seq=%0d last=%0d st=%0d rem=%0d",
                             $realtime, w.blk, w.vld, w.seqf, w.fin, w.st, w.rem);
                    $display("%0t:   actual blk=%h v=%0d seq=%0d last=%0d st=%0d rem=%0d",
                             $realtime, block_out, valid_res, sequential, last, status,
                             removed);
                    errors++;
                end
            end
        end
    end

    // advance on any accepted request, age write or result; give up when stuck
    int idle_cycles;
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    req_row_t directed[$];

    initial begin
        req_row_t r;
        errors = 0;
        quiet = 0;
        hold_req = 0;
        clock_ts = 64'd1000;
        age_limit = 64'd1000000000;
        for (int s = 0; s < NSEQ; s++) begin
            seq_live[s] = 0; seq_depth[s] = 0; seq_is_stride[s] = 0; seq_next_guess[s] = 0;
            seq_key[s] = 0; seq_seen_at[s] = 0; seq_prev_blk[s] = 0;
        end
        for (int i = 0; i < NSEQ*NCNT; i++) begin
            cnt_live[i] = 0; cnt_blk[i] = 0; cnt_hits[i] = 0;
        end
        id_pool[0] = 64'd0;
        id_pool[1] = '1;
        for (int k = 2; k < 20; k++)
            id_pool[k] = {$urandom, $urandom};
        for (int k = 0; k < 20; k++)
            pool_blk[k] = $urandom;
        rst_n = 1'b0;
        cfg_valid = 1'b0; max_age = '0;
        in_valid = 1'b0; func = FN_NOP; sequence_id = '0; block_id = '0;
        timestamp = '0; num_predictions = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown sequence, no-op, empty cleanup, wrap, ties, clamps
        r = plain_row(FN_PREDICT, '1, 0, 0, 5'd4);
        r.typed = 1; r.want = '{0, 0, 0, 1, ST_NOT_FOUND, 0};
        directed = {directed, r};
        r = plain_row(FN_NOP, '1, '1, '1, '1);
        r.typed = 1; r.want = '{0, 0, 0, 1, ST_OK, 0};
        directed = {directed, r};
        r = plain_row(FN_CLEANUP, 0, 0, '1, 0);
        r.typed = 1; r.want = '{0, 0, 0, 1, ST_OK, 0};
        directed = {directed, r};
        directed = {directed, plain_row(FN_RECORD, '1, '1, 0, 0)};
        directed = {directed, plain_row(FN_RECORD, '1, 0, 5, 0)};
        directed = {directed, plain_row(FN_RECORD, '1, 1, 6, 0)};
        directed = {directed, plain_row(FN_PREDICT, '1, 0, 0, 5'd16)};
        directed = {directed, plain_row(FN_PREDICT, '1, 0, 0, 5'd31)};
        directed = {directed, plain_row(FN_PREDICT, '1, 0, 0, 5'd0)};
        directed = {directed, plain_row(FN_RECORD, 0, 5, 7, 0)};
        directed = {directed, plain_row(FN_PREDICT, 0, 0, 0, 5'd1)};
        directed = {directed, plain_row(FN_RECORD, 0, 5, 8, 0)};
        directed = {directed, plain_row(FN_RECORD, 0, 9, 9, 0)};
        directed = {directed, plain_row(FN_RECORD, 0, 2, 10, 0)};
        directed = {directed, plain_row(FN_PREDICT, 0, 0, 0, 5'd4)};
        directed = {directed, plain_row(FN_RECORD, 0, 9, 11, 0)};
        directed = {directed, plain_row(FN_PREDICT, 0, 0, 0, 5'd31)};
        r = plain_row(FN_CLEANUP, 0, 0, '1, 0);
        r.typed = 1; r.want = '{0, 0, 0, 1, ST_OK, 5'd2};
        directed = {directed, r};
        foreach (directed[i])
            send_request(directed[i]);

        // fill the sequence table, overflow it, then overflow one count table
        for (int k = 0; k <= NSEQ; k++)
            send_request(plain_row(FN_RECORD, 64'(k + 100), 32'(k), 64'd20, 0));
        for (int k = 1; k <= NCNT; k++)
            send_request(plain_row(FN_RECORD, 64'd100, 32'(k * 3), 64'd21, 0));
        send_request(plain_row(FN_PREDICT, 64'd100, 0, 0, 5'd16));
        send_request(plain_row(FN_CLEANUP, 0, 0, 64'd2000000000, 0));

        for (int n = 0; n < 60; n++)
            send_request(random_row());
        drain_results();

        write_age_limit(64'd0);
        for (int n = 0; n < 30; n++)
            send_request(random_row());
        drain_results();

        write_age_limit(64'd300);
        hold_req = 1;
        for (int n = 0; n < 70; n++)
            send_request(random_row());
        drain_results();

        write_age_limit('1);
        quiet = 1;
        for (int n = 0; n < 50; n++)
            send_request(random_row());
        drain_results();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
